// ===== src/cycle_sync_morph_resampler_core_defines.svh =====
// Assertion macros shared by the cycle morphing resampler RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef CYCLE_SYNC_MORPH_RESAMPLER_CORE_DEFINES_SVH
`define CYCLE_SYNC_MORPH_RESAMPLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CSMR_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("csmr: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CSMR_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("csmr: next-cycle check failed");

`endif

// ===== src/csmr_pkg.sv =====
// Shared widths, request codes and types of the cycle morphing resampler.
// Depends on nothing; used by the divider and the top level.
package csmr_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int ADDR_W    = 10;
  localparam int LEN_W     = 11;
  localparam int RATIO_W   = 17;
  localparam int FRAC_W    = 16;
  localparam int POS_W     = 26;
  localparam int STEP_W    = 27;
  localparam int IDX_W     = POS_W - FRAC_W;
  localparam int INTERP_W  = 32;
  localparam int MIX_W     = 48;

  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

  typedef enum logic [1:0] {
    REQ_LOAD_A  = 2'd0,
    REQ_LOAD_B  = 2'd1,
    REQ_START   = 2'd2,
    REQ_PRODUCE = 2'd3
  } req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== src/csmr_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// Depends on nothing.
module csmr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== src/csmr_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Depends on csmr_pkg for its status type.
module csmr_div #(
  parameter int DIVIDEND_W = 27,
  parameter int DIVISOR_W  = 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_W-1:0]    dividend,
  input  logic [DIVISOR_W-1:0]     divisor,
  output logic [DIVIDEND_W-1:0]    quotient,
  output csmr_pkg::div_status_t    status
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVIDEND_W-1:0] quo;
  logic [CW-1:0]         cnt;
  logic                  busy;
  logic                  done;
  logic [DIVISOR_W:0]    shifted;
  logic                  fits;

  assign shifted  = {rem, quo[DIVIDEND_W-1]};
  assign fits     = shifted >= {1'b0, dvs};
  assign quotient = quo;
  assign status   = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DIVISOR_W'(shifted - {1'b0, dvs});
        quo <= {quo[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIVISOR_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== src/cycle_sync_morph_resampler_core.sv =====
// Top level of the cycle morphing resampler; uses csmr_pkg, csmr_ram, csmr_div
// and the assertion macros in cycle_sync_morph_resampler_core_defines.svh.
// Requests arrive as beats on the s_ channel, req_type in s_tuser. Load beats
// write one sample into store A or B. A start beat sets both cycle lengths,
// derives the output length from the mix ratio and runs two bit-serial
// dividers with 27 quotient bits for the read increments, passing through
// ST_MUL, ST_LEN and ST_DIV. Each produce beat yields one result beat on the
// m_ channel: in an active cycle the stores are read at the current
// positions and interpolated in ST_RD, crossfaded in ST_MIX and rounded
// into the output register in ST_RND. m_tlast marks the final sample of a
// cycle; m_tuser flags a produce that came with no active cycle. mix_ratio
// is written through cfg_we/cfg_wdata. Reset clears the cycle state and
// sets the ratio to one half; the sample stores are not cleared. When the
// receiver stalls, the result waits in the output register and loads and
// starts are still taken; a further produce waits in its final step until
// the output register is free.
`include "cycle_sync_morph_resampler_core_defines.svh"

module cycle_sync_morph_resampler_core #(
  parameter int CYCLE_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [csmr_pkg::RATIO_W-1:0]       cfg_wdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // sample_addr, sample_value, cycle_len_a, cycle_len_b
  input  logic [47:0]                        s_tdata,
  // req_type
  input  logic [1:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // out_sample
  output logic [csmr_pkg::SAMPLE_W-1:0]      m_tdata,
  output logic                               m_tlast,
  // status
  output logic                               m_tuser
);

  localparam int AW      = $clog2(CYCLE_DEPTH);
  localparam int SW      = csmr_pkg::SAMPLE_W;
  localparam int LW      = csmr_pkg::LEN_W;
  localparam int FW      = csmr_pkg::FRAC_W;
  localparam int PW      = csmr_pkg::POS_W;
  localparam int QW      = csmr_pkg::STEP_W;
  localparam int IW      = csmr_pkg::IDX_W;
  localparam int RW      = csmr_pkg::RATIO_W;
  localparam int VW      = csmr_pkg::INTERP_W;
  localparam int TW      = csmr_pkg::MIX_W;
  localparam int DPW     = LW + RW + 1;
  localparam int DELTA_W = DPW - FW;
  localparam int RSW     = TW + 1;
  localparam logic signed [RSW-1:0] HALF    = RSW'(64'sd2147483648);
  localparam logic signed [RSW-1:0] HALF_M1 = RSW'(64'sd2147483647);
  localparam logic signed [SW:0]    QMAX    = (SW+1)'(32767);
  localparam logic signed [SW:0]    QMIN    = -(SW+1)'(32768);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL  = 8'b0000_0010,
    ST_LEN  = 8'b0000_0100,
    ST_DIV  = 8'b0000_1000,
    ST_RD   = 8'b0001_0000,
    ST_MIX  = 8'b0010_0000,
    ST_RND  = 8'b0100_0000,
    ST_ERR  = 8'b1000_0000
  } state_t;

  function automatic logic [LW-1:0] clamp_len(input logic [LW-1:0] l);
    logic [LW-1:0] r;
    r = l;
    if (l == '0) begin
      r = LW'(1);
    end else if (32'(l) > CYCLE_DEPTH) begin
      r = LW'(CYCLE_DEPTH);
    end
    return r;
  endfunction

  function automatic logic signed [VW-1:0] interp(input logic signed [SW-1:0] s0,
                                                  input logic signed [SW-1:0] s1,
                                                  input logic [FW-1:0] frac);
    logic signed [SW:0]      diff;
    logic signed [FW:0]      fs;
    logic signed [SW+FW+1:0] prod;
    logic signed [SW+FW+1:0] sum;
    diff = (SW+1)'(s1) - (SW+1)'(s0);
    fs   = $signed({1'b0, frac});
    prod = diff * fs;
    sum  = ((SW+FW+2)'(s0) <<< FW) + prod;
    return VW'(sum);
  endfunction

  state_t               state;
  logic [RW-1:0]        mix_ratio;
  logic [RW-1:0]        r_eff;
  logic [LW-1:0]        len_a_reg;
  logic [LW-1:0]        len_b_reg;
  logic [LW-1:0]        out_len;
  logic [LW-1:0]        out_index;
  logic [PW-1:0]        pos_a;
  logic [PW-1:0]        pos_b;
  logic [QW-1:0]        step_a;
  logic [QW-1:0]        step_b;
  logic                 active;

  logic                 s_fire;
  csmr_pkg::req_t       req;
  logic [csmr_pkg::ADDR_W-1:0] in_addr;
  logic [SW-1:0]        in_value;
  logic [LW-1:0]        la_c;
  logic [LW-1:0]        lb_c;
  logic                 grow;
  logic [LW-1:0]        d_reg;
  logic [DPW-1:0]       prod_reg;
  logic [DELTA_W-1:0]   delta;
  logic [LW-1:0]        out_len_next;

  logic                 addr_ok;
  logic                 we_a;
  logic                 we_b;
  logic [IW-1:0]        idx_a;
  logic [IW-1:0]        idx_b;
  logic [LW-1:0]        idx_a1;
  logic [LW-1:0]        idx_b1;
  logic [SW-1:0]        ra0, ra1, rb0, rb1;
  logic signed [SW-1:0] sa0, sa1, sb0, sb1;

  logic signed [VW-1:0] va;
  logic signed [VW-1:0] vb;
  logic signed [VW:0]   dv;
  logic signed [RW:0]   rs;
  logic signed [TW+2:0] t_full;
  logic signed [TW-1:0] t_reg;
  logic signed [RSW-1:0] rsum;
  logic signed [SW:0]   q;
  logic [SW-1:0]        q_sat;

  logic                 div_start;
  logic [QW-1:0]        quo_a;
  logic [QW-1:0]        quo_b;
  csmr_pkg::div_status_t stat_a;
  csmr_pkg::div_status_t stat_b;

  logic                 out_free;
  logic                 out_load;
  logic [LW:0]          idx_inc;
  logic                 res_last;

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign req      = csmr_pkg::req_t'(s_tuser);
  assign in_addr  = s_tdata[9:0];
  assign in_value = s_tdata[25:10];
  assign la_c     = clamp_len(s_tdata[36:26]);
  assign lb_c     = clamp_len(s_tdata[47:37]);
  assign r_eff    = (mix_ratio > csmr_pkg::RATIO_ONE) ? csmr_pkg::RATIO_ONE : mix_ratio;

  // Loads and reads never share an edge, so the stores need no forwarding.
  assign addr_ok = 32'(in_addr) < CYCLE_DEPTH;
  assign we_a    = s_fire && (req == csmr_pkg::REQ_LOAD_A) && addr_ok;
  assign we_b    = s_fire && (req == csmr_pkg::REQ_LOAD_B) && addr_ok;
  assign idx_a   = pos_a[PW-1:FW];
  assign idx_b   = pos_b[PW-1:FW];
  assign idx_a1  = LW'(idx_a) + LW'(1);
  assign idx_b1  = LW'(idx_b) + LW'(1);

  csmr_ram #(.WIDTH(SW), .DEPTH(CYCLE_DEPTH)) u_store_a (
    .clk(clk), .we(we_a), .waddr(AW'(in_addr)), .wdata(in_value),
    .raddr0(AW'(idx_a)), .raddr1(AW'(idx_a1)), .rdata0(ra0), .rdata1(ra1)
  );

  csmr_ram #(.WIDTH(SW), .DEPTH(CYCLE_DEPTH)) u_store_b (
    .clk(clk), .we(we_b), .waddr(AW'(in_addr)), .wdata(in_value),
    .raddr0(AW'(idx_b)), .raddr1(AW'(idx_b1)), .rdata0(rb0), .rdata1(rb1)
  );

  // Reads past the end of a cycle count as zero.
  assign sa0 = (LW'(idx_a) < len_a_reg) ? $signed(ra0) : '0;
  assign sa1 = (idx_a1 < len_a_reg) ? $signed(ra1) : '0;
  assign sb0 = (LW'(idx_b) < len_b_reg) ? $signed(rb0) : '0;
  assign sb1 = (idx_b1 < len_b_reg) ? $signed(rb1) : '0;

  assign delta        = prod_reg[DPW-1:FW];
  assign out_len_next = grow ? LW'(DELTA_W'(len_a_reg) + delta)
                             : LW'(DELTA_W'(len_a_reg) - delta);
  assign div_start    = (state == ST_LEN);

  csmr_div #(.DIVIDEND_W(QW), .DIVISOR_W(LW)) u_div_a (
    .clk(clk), .rst(rst), .start(div_start), .dividend({len_a_reg, FW'(0)}),
    .divisor(out_len_next), .quotient(quo_a), .status(stat_a)
  );

  csmr_div #(.DIVIDEND_W(QW), .DIVISOR_W(LW)) u_div_b (
    .clk(clk), .rst(rst), .start(div_start), .dividend({len_b_reg, FW'(0)}),
    .divisor(out_len_next), .quotient(quo_b), .status(stat_b)
  );

  // Crossfade as va + (vb - va) * r, one multiplier.
  assign dv     = (VW+1)'(vb) - (VW+1)'(va);
  assign rs     = $signed({1'b0, r_eff});
  assign t_full = ((TW+3)'(va) <<< FW) + dv * rs;

  // Round half away from zero, then saturate.
  assign rsum  = RSW'(t_reg) + (t_reg[TW-1] ? HALF_M1 : HALF);
  assign q     = rsum[RSW-1:32];
  assign q_sat = (q > QMAX) ? SW'(QMAX) : (q < QMIN) ? SW'(QMIN) : SW'(q);

  assign idx_inc  = (LW+1)'(out_index) + (LW+1)'(1);
  assign res_last = idx_inc >= (LW+1)'(out_len);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = ((state == ST_RND) || (state == ST_ERR)) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_ratio <= csmr_pkg::RATIO_ONE >> 1;
    end else if (cfg_we) begin
      mix_ratio <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      len_a_reg <= '0;
      len_b_reg <= '0;
      out_len   <= '0;
      out_index <= '0;
      pos_a     <= '0;
      pos_b     <= '0;
      step_a    <= '0;
      step_b    <= '0;
      active    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            unique case (req)
              csmr_pkg::REQ_LOAD_A, csmr_pkg::REQ_LOAD_B: begin
              end
              csmr_pkg::REQ_START: begin
                len_a_reg <= la_c;
                len_b_reg <= lb_c;
                out_index <= '0;
                active    <= 1'b0;
                state     <= ST_MUL;
              end
              csmr_pkg::REQ_PRODUCE: begin
                state <= active ? ST_RD : ST_ERR;
              end
            endcase
          end
        end
        ST_MUL: begin
          state <= ST_LEN;
        end
        ST_LEN: begin
          out_len <= out_len_next;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          if (stat_a.done) begin
            step_a <= quo_a;
            step_b <= quo_b;
            pos_a  <= '0;
            pos_b  <= '0;
            active <= 1'b1;
            state  <= ST_IDLE;
          end
        end
        ST_RD: begin
          state <= ST_MIX;
        end
        ST_MIX: begin
          state <= ST_RND;
        end
        ST_RND: begin
          if (out_free) begin
            pos_a     <= PW'(QW'(pos_a) + step_a);
            pos_b     <= PW'(QW'(pos_b) + step_b);
            out_index <= LW'(idx_inc);
            if (res_last) begin
              active <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        ST_ERR: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      grow  <= lb_c >= la_c;
      d_reg <= (lb_c >= la_c) ? (lb_c - la_c) : (la_c - lb_c);
    end
    if (state == ST_MUL) begin
      prod_reg <= DPW'(d_reg) * DPW'(r_eff) + DPW'(32768);
    end
    if (state == ST_RD) begin
      va <= interp(sa0, sa1, pos_a[FW-1:0]);
      vb <= interp(sb0, sb1, pos_b[FW-1:0]);
    end
    if (state == ST_MIX) begin
      t_reg <= TW'(t_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_ERR) begin
        m_tdata <= '0;
        m_tlast <= 1'b0;
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= q_sat;
        m_tlast <= res_last;
        m_tuser <= 1'b0;
      end
    end
  end

  `CSMR_ASSERT_NOW(a_div_holds_input, clk, rst, stat_a.busy || stat_b.busy, !s_tready)
  `CSMR_ASSERT_NEXT(a_last_ends_cycle, clk, rst, out_load && (state == ST_RND) && res_last, !active)
  `CSMR_ASSERT_NOW(a_index_in_cycle, clk, rst, active, out_index < out_len)
  `CSMR_ASSERT_NOW(a_status_beat, clk, rst, m_tvalid && m_tuser, !m_tlast && (m_tdata == '0))

endmodule

// ===== test/tb_cycle_sync_morph_resampler_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for cycle_sync_morph_resampler_core, built on csmr_pkg.
// Sends load, start and produce beats with random gaps and output stalls, predicts
// each result beat with its own fixed-point model and compares every field.
module tb_cycle_sync_morph_resampler_core;
  import csmr_pkg::*;

  localparam int DEPTH = 1024;
  localparam int SETTLE_CYCLES = 40;
  localparam int ITEM_TARGET = 1600;
  localparam int NUM_PHASES = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int PRINT_CAP = 100;
  localparam longint LIMIT_NS = 64'd20_000_000;
  localparam logic ST_OK = 1'b0;
  localparam logic ST_NO_CYCLE = 1'b1;
  localparam int unsigned RATIO_MAX = (1 << RATIO_W) - 1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                status;
  } morph_beat_t;

  typedef struct {
    bit   cfg;
    req_t kind;
    int   addr;
    int   value;
    int   len_a;
    int   len_b;
    bit   no_cycle;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [RATIO_W-1:0] cfg_wdata = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  // sample_addr, sample_value, cycle_len_a, cycle_len_b
  logic [47:0]        s_tdata = '0;
  // req_type
  logic [1:0]         s_tuser = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // out_sample
  logic [SAMPLE_W-1:0] m_tdata;
  logic               m_tlast;
  // status
  logic               m_tuser;

  logic signed [SAMPLE_W-1:0] store_a_q [DEPTH];
  logic signed [SAMPLE_W-1:0] store_b_q [DEPTH];
  bit                 written_a [DEPTH];
  bit                 written_b [DEPTH];
  int unsigned        len_a_q = 0, len_b_q = 0, out_len_q = 0, out_idx_q = 0;
  logic [POS_W-1:0]   pos_a_q = '0, pos_b_q = '0;
  logic [STEP_W-1:0]  step_a_q = '0, step_b_q = '0;
  bit                 cycle_on = 1'b0;
  logic [RATIO_W-1:0] ratio_q = RATIO_ONE >> 1;

  morph_beat_t expected_samples [$];
  int err_count = 0;
  int beats_sent = 0;
  int hold_len = 0;
  bit no_gaps = 1'b0;
  plan_row_t plan [24];

  always #5 clk = ~clk;

  cycle_sync_morph_resampler_core #(
    .CYCLE_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  task automatic flag_mismatch(input string what);
    if (err_count < PRINT_CAP) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
    err_count++;
  endtask

  function automatic int unsigned clamp_len(input int unsigned raw);
    if (raw == 0) return 1;
    if (raw > DEPTH) return DEPTH;
    return raw;
  endfunction

  function automatic longint unsigned eff_ratio();
    return (ratio_q > RATIO_ONE) ? RATIO_ONE : ratio_q;
  endfunction

  function automatic void plan_cycle(input int unsigned la_raw, input int unsigned lb_raw,
                                     output int unsigned la, output int unsigned lb,
                                     output int unsigned olen,
                                     output logic [STEP_W-1:0] sa,
                                     output logic [STEP_W-1:0] sb);
    longint unsigned d, delta;
    la = clamp_len(la_raw);
    lb = clamp_len(lb_raw);
    d = (lb >= la) ? lb - la : la - lb;
    delta = (d * eff_ratio() + 64'd32768) >> 16;
    olen = (lb >= la) ? la + delta : la - delta;
    sa = STEP_W'((longint'(la) << 16) / olen);
    sb = STEP_W'((longint'(lb) << 16) / olen);
  endfunction

  function automatic longint read_interp(input bit from_b, input int unsigned len,
                                         input logic [POS_W-1:0] pos);
    int unsigned i;
    longint f, a, e;
    i = pos[POS_W-1:FRAC_W];
    f = longint'(pos[FRAC_W-1:0]);
    a = 0;
    e = 0;
    if (i < len) a = from_b ? store_b_q[i] : store_a_q[i];
    if (i + 1 < len) e = from_b ? store_b_q[i+1] : store_a_q[i+1];
    return a * 65536 + (e - a) * f;
  endfunction

  function automatic bit predict_morph(input req_t kind, input int unsigned addr,
                                       input logic [SAMPLE_W-1:0] value,
                                       input int unsigned la_raw, input int unsigned lb_raw,
                                       output morph_beat_t res);
    longint va, vb, t, q, r, hi;
    res = '0;
    case (kind)
      REQ_LOAD_A: begin
        store_a_q[addr] = value;
        written_a[addr] = 1'b1;
        return 1'b0;
      end
      REQ_LOAD_B: begin
        store_b_q[addr] = value;
        written_b[addr] = 1'b1;
        return 1'b0;
      end
      REQ_START: begin
        plan_cycle(la_raw, lb_raw, len_a_q, len_b_q, out_len_q, step_a_q, step_b_q);
        pos_a_q = '0;
        pos_b_q = '0;
        out_idx_q = 0;
        cycle_on = 1'b1;
        return 1'b0;
      end
      default: ;
    endcase
    if (!cycle_on) begin
      res.status = ST_NO_CYCLE;
      return 1'b1;
    end
    r = longint'(eff_ratio());
    va = read_interp(1'b0, len_a_q, pos_a_q);
    vb = read_interp(1'b1, len_b_q, pos_b_q);
    t = va * (longint'(RATIO_ONE) - r) + vb * r;
    if (t >= 0) q = (t + 64'sd2147483648) >>> 32;
    else q = -((-t + 64'sd2147483648) >>> 32);
    hi = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    if (q > hi) q = hi;
    if (q < -hi - 1) q = -hi - 1;
    res.sample = q[SAMPLE_W-1:0];
    res.status = ST_OK;
    pos_a_q = POS_W'(pos_a_q + step_a_q);
    pos_b_q = POS_W'(pos_b_q + step_b_q);
    out_idx_q++;
    res.last = (out_idx_q >= out_len_q);
    if (res.last) cycle_on = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_request(input req_t kind, input int unsigned addr, input int value,
                              input int unsigned la_raw, input int unsigned lb_raw,
                              input bit no_cycle = 1'b0);
    int gap;
    bit has_res;
    morph_beat_t res;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {LEN_W'(lb_raw), LEN_W'(la_raw), SAMPLE_W'(value), ADDR_W'(addr)};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    beats_sent++;
    has_res = predict_morph(kind, addr, SAMPLE_W'(value), la_raw, lb_raw, res);
    if (has_res) begin
      if (no_cycle) begin
        res = '{sample: '0, last: 1'b0, status: ST_NO_CYCLE};
      end
      expected_samples.push_back(res);
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ratio(input int unsigned value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= RATIO_W'(value);
    @(posedge clk);
    cfg_we  <= 1'b0;
    ratio_q = RATIO_W'(value);
  endtask

  function automatic int rand_sample();
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      2: return 0;
      3: return -1;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int unsigned pick_len();
    case ($urandom_range(0, 39))
      0: return 0;
      1: return $urandom_range(DEPTH - 24, 2047);
      default: return $urandom_range(1, 48);
    endcase
  endfunction

  // Loads every store entry that the coming cycle will read and that has
  // never been written, so that no read ever touches an unwritten entry.
  task automatic fill_needed(input bit from_b, input int unsigned len,
                             input logic [STEP_W-1:0] step, input int unsigned olen);
    logic [POS_W-1:0] p;
    int unsigned i;
    p = '0;
    for (int unsigned k = 0; k < olen; k++) begin
      i = p[POS_W-1:FRAC_W];
      for (int unsigned j = i; j <= i + 1 && j < len; j++) begin
        if (!(from_b ? written_b[j] : written_a[j])) begin
          send_request(from_b ? REQ_LOAD_B : REQ_LOAD_A, j, rand_sample(), $urandom, $urandom);
        end
      end
      p = POS_W'(p + step);
    end
  endtask

  task automatic run_cycle();
    int unsigned la_raw, lb_raw, la, lb, olen, n_prod;
    logic [STEP_W-1:0] sa, sb;
    la_raw = pick_len();
    lb_raw = pick_len();
    plan_cycle(la_raw, lb_raw, la, lb, olen, sa, sb);
    fill_needed(1'b0, la, sa, olen);
    fill_needed(1'b1, lb, sb, olen);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        send_request($urandom_range(0, 1) ? REQ_LOAD_B : REQ_LOAD_A,
                     $urandom_range(0, DEPTH - 1), rand_sample(), $urandom, $urandom);
      end
    end
    send_request(REQ_START, $urandom_range(0, DEPTH - 1), $urandom, la_raw, lb_raw);
    n_prod = olen;
    case ($urandom_range(0, 9))
      0: n_prod = $urandom_range(0, olen - 1);
      1: n_prod = olen + $urandom_range(1, 2);
      default: ;
    endcase
    for (int unsigned k = 0; k < n_prod; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_request($urandom_range(0, 1) ? REQ_LOAD_B : REQ_LOAD_A,
                     $urandom_range(0, DEPTH - 1), rand_sample(), $urandom, $urandom);
      end
      send_request(REQ_PRODUCE, $urandom_range(0, DEPTH - 1), $urandom, $urandom, $urandom);
    end
  endtask

  initial begin : result_sink
    int gap;
    morph_beat_t want;
    wait (rst == 1'b0);
    forever begin
      if (hold_len > 0) begin
        gap = hold_len;
        hold_len = 0;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 10);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (m_tvalid !== 1'b1) @(posedge clk);
      if (expected_samples.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing expected, sample %0d",
                                $signed(m_tdata)));
      end else begin
        want = expected_samples.pop_front();
        if (m_tdata !== want.sample)
          flag_mismatch($sformatf("out_sample %0d, expected %0d",
                                  $signed(m_tdata), $signed(want.sample)));
        if (m_tlast !== want.last)
          flag_mismatch($sformatf("cycle_last %b, expected %b", m_tlast, want.last));
        if (m_tuser !== want.status)
          flag_mismatch($sformatf("status %b, expected %b", m_tuser, want.status));
      end
    end
  end

  initial begin : stimulus
    int unsigned target;
    int unsigned ratio;
    plan = '{
      '{1'b0, REQ_PRODUCE, 0, 0, 0, 0, 1'b1},
      '{1'b0, REQ_LOAD_A, 0, 32767, 0, 0, 1'b0},
      '{1'b0, REQ_LOAD_A, 1, -32768, 0, 0, 1'b0},
      '{1'b0, REQ_LOAD_B, 0, -32768, 0, 0, 1'b0},
      '{1'b0, REQ_LOAD_B, 1, 32767, 0, 0, 1'b0},
      '{1'b0, REQ_LOAD_A, 1023, 21845, 2047, 2047, 1'b0},
      '{1'b0, REQ_LOAD_B, 1023, -21846, 0, 0, 1'b0},
      '{1'b0, REQ_START, 1023, -1, 1, 1, 1'b0},
      '{1'b0, REQ_PRODUCE, 0, 0, 0, 0, 1'b0},
      '{1'b0, REQ_PRODUCE, 1023, -1, 2047, 2047, 1'b1},
      '{1'b0, REQ_START, 0, 0, 0, 2, 1'b0},
      '{1'b0, REQ_PRODUCE, 0, 0, 0, 0, 1'b0},
      '{1'b0, REQ_LOAD_A, 0, -1, 0, 0, 1'b0},
      '{1'b0, REQ_START, 0, 0, 2, 2, 1'b0},
      '{1'b0, REQ_PRODUCE, 0, 0, 0, 0, 1'b0},
      '{1'b0, REQ_PRODUCE, 0, 0, 0, 0, 1'b0},
      '{1'b1, REQ_LOAD_A, 0, int'(RATIO_ONE), 0, 0, 1'b0},
      '{1'b0, REQ_START, 0, 0, 2047, 0, 1'b0},
      '{1'b0, REQ_PRODUCE, 0, 0, 0, 0, 1'b0},
      '{1'b1, REQ_LOAD_A, 0, 0, 0, 0, 1'b0},
      '{1'b0, REQ_START, 0, 0, 2, 1, 1'b0},
      '{1'b0, REQ_PRODUCE, 0, 0, 0, 0, 1'b0},
      '{1'b0, REQ_PRODUCE, 0, 0, 0, 0, 1'b0},
      '{1'b0, REQ_PRODUCE, 0, 0, 0, 0, 1'b1}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[n]) begin
      if (plan[n].cfg) begin
        write_ratio(plan[n].value);
      end else begin
        send_request(plan[n].kind, plan[n].addr, plan[n].value, plan[n].len_a,
                     plan[n].len_b, plan[n].no_cycle);
      end
    end
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: ratio = RATIO_ONE >> 1;
        1: ratio = 0;
        2: ratio = RATIO_ONE;
        3: ratio = RATIO_MAX;
        4: ratio = 1;
        5: ratio = RATIO_ONE - 1;
        default: ratio = $urandom_range(0, RATIO_MAX);
      endcase
      write_ratio(ratio);
      if (ph == 3) hold_len = HOLD_CYCLES;
      no_gaps = (ph == 5);
      target = beats_sent + ITEM_TARGET / NUM_PHASES;
      while (beats_sent < target) run_cycle();
    end
    settle();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/csmr_pkg.sv
src/csmr_ram.sv
src/csmr_div.sv
src/cycle_sync_morph_resampler_core.sv
test/tb_cycle_sync_morph_resampler_core.sv
